FILE: hdl/hirt_pkg.sv
package hirt_pkg;

   localparam int TableEntries = 1024;
   localparam int IdxW = $clog2(TableEntries);
   localparam int CntW = $clog2(TableEntries + 1);
   localparam logic [31:0] HeightMax = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_PUSH     = 2'd0,
      CMD_POP      = 2'd1,
      CMD_TRUNCATE = 2'd2,
      CMD_QUERY    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_OVERFLOW = 2'd1,
      STS_FULL     = 2'd2,
      STS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic {
      ALU_INTEREST = 1'b0,
      ALU_AMOUNT   = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [31:0] height;
      logic [62:0] amount;
      logic [63:0] interest;
   } entry_type;

   typedef struct packed {
      logic            wr_en;
      logic [IdxW-1:0] wr_addr;
      entry_type       wr_data;
      logic            rd_en;
      logic [IdxW-1:0] rd_addr;
   } tbl_ctl_type;

endpackage

FILE: hdl/hirt_req_if.sv
interface hirt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [63:0] block_amount;
   logic [63:0]        block_interest;
   logic [31:0]        query_height;

   modport source (output valid, cmd, block_amount, block_interest, query_height,
                   input ready);
   modport sink (input valid, cmd, block_amount, block_interest, query_height,
                 output ready);
endinterface

FILE: hdl/hirt_rsp_if.sv
interface hirt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] removed_blocks;
   logic [62:0] amount_at;
   logic [63:0] interest_at;
   logic [31:0] current_height;
   logic [62:0] total_amount;
   logic [63:0] total_interest;

   modport source (output valid, status, removed_blocks, amount_at, interest_at,
                   current_height, total_amount, total_interest,
                   input ready);
   modport sink (input valid, status, removed_blocks, amount_at, interest_at,
                 current_height, total_amount, total_interest,
                 output ready);
endinterface

FILE: hdl/hirt_table.sv
module hirt_table (
   input  logic                  clock,
   input  hirt_pkg::tbl_ctl_type ctl,
   output hirt_pkg::entry_type   rd_data
);

   hirt_pkg::entry_type entry_mem_ff [hirt_pkg::TableEntries];
   hirt_pkg::entry_type rd_word_ff;
   logic                rd_zero_ff;

   // Entry zero is never written and always reads as zero.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= entry_mem_ff[ctl.rd_addr];
         rd_zero_ff <= (ctl.rd_addr == '0);
      end
   end

   assign rd_data = rd_zero_ff ? '0 : rd_word_ff;

endmodule

FILE: hdl/hirt_alu.sv
module hirt_alu (
   input  hirt_pkg::alu_op_type op,
   input  logic [62:0]          last_amount,
   input  logic [63:0]          last_interest,
   input  logic signed [63:0]   block_amount,
   input  logic [63:0]          block_interest,
   output logic [63:0]          sum,
   output logic                 fault
);

   logic [64:0] opa;
   logic [64:0] opb;
   logic [64:0] total;

   always_comb begin
      if (op == hirt_pkg::ALU_AMOUNT) begin
         opa = {2'b00, last_amount};
         opb = {block_amount[63], block_amount};
      end else begin
         opa = {1'b0, last_interest};
         opb = {1'b0, block_interest};
      end
      total = opa + opb;
      sum = total[63:0];
      // The amount must stay within 0 to 2^63-1; the interest must not carry out.
      if (op == hirt_pkg::ALU_AMOUNT) begin
         fault = total[64] | total[63];
      end else begin
         fault = total[64];
      end
   end

endmodule

FILE: hdl/height_indexed_running_totals_top.sv
// Channel  Direction  Contents
// req_ch   in         cmd, block_amount, block_interest, query_height
// rsp_ch   out        status, removed_blocks, amount_at, interest_at, current_height,
//                     total_amount, total_interest
//
// Push runs the decode and push states, both on the shared adder (interest, then amount);
// pop goes from decode to done, or through the load state when the new last entry is read back
// from the table memory. Query and truncate run decode, one search step per binary search
// step over the table memory, then load and done; a truncate above the chain height goes
// from decode straight to done.
// One word is in work at a time; the next is taken once the result is registered.
// Reset is synchronous; the table needs no clearing pass after it.
// A stalled result holds in the output register while the next word is taken.
module height_indexed_running_totals_top (
   input logic clock,
   input logic reset,
   hirt_req_if.sink   req_ch,
   hirt_rsp_if.source rsp_ch
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_PUSH   = 6'b000100,
      S_SEARCH = 6'b001000,
      S_LOAD   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   localparam int CntW = hirt_pkg::CntW;
   localparam int IdxW = hirt_pkg::IdxW;

   state_type            state_ff, state_in;
   hirt_pkg::cmd_type    cmd_ff, cmd_in;
   logic signed [63:0]   amt_ff, amt_in;
   logic [63:0]          int_ff, int_in;
   logic [31:0]          qh_ff, qh_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [31:0]          chain_ff, chain_in;
   logic [31:0]          last_hgt_ff, last_hgt_in;
   logic [62:0]          last_amt_ff, last_amt_in;
   logic [63:0]          last_int_ff, last_int_in;
   logic [CntW-1:0]      lo_ff, lo_in;
   logic [CntW-1:0]      hi_ff, hi_in;
   logic [CntW-1:0]      mid_ff, mid_in;
   logic [31:0]          key_ff, key_in;
   logic [63:0]          new_int_ff, new_int_in;
   logic                 int_fault_ff, int_fault_in;
   hirt_pkg::status_type status_ff, status_in;
   logic [31:0]          removed_ff, removed_in;
   logic [62:0]          at_amt_ff, at_amt_in;
   logic [63:0]          at_int_ff, at_int_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_removed_ff, rsp_removed_in;
   logic [62:0]          rsp_at_amt_ff, rsp_at_amt_in;
   logic [63:0]          rsp_at_int_ff, rsp_at_int_in;
   logic [31:0]          rsp_height_ff, rsp_height_in;
   logic [62:0]          rsp_tot_amt_ff, rsp_tot_amt_in;
   logic [63:0]          rsp_tot_int_ff, rsp_tot_int_in;

   hirt_pkg::tbl_ctl_type tbl_ctl;
   hirt_pkg::entry_type   tbl_rd;
   hirt_pkg::alu_op_type  alu_op;
   logic [63:0]           alu_sum;
   logic                  alu_fault;

   logic                  req_fire;
   logic [31:0]           from_h;
   logic                  le;
   logic [CntW-1:0]       nlo;
   logic [CntW-1:0]       nhi;
   logic [CntW-1:0]       nmid;
   logic [CntW-1:0]       cnt_m1;
   logic [CntW-1:0]       cnt_m2;
   logic [CntW-1:0]       nlo_m1;
   logic                  push_fault;
   logic                  push_adds;

   hirt_table u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .rd_data (tbl_rd)
   );

   hirt_alu u_alu (
      .op             (alu_op),
      .last_amount    (last_amt_ff),
      .last_interest  (last_int_ff),
      .block_amount   (amt_ff),
      .block_interest (int_ff),
      .sum            (alu_sum),
      .fault          (alu_fault)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.removed_blocks = rsp_removed_ff;
   assign rsp_ch.amount_at      = rsp_at_amt_ff;
   assign rsp_ch.interest_at    = rsp_at_int_ff;
   assign rsp_ch.current_height = rsp_height_ff;
   assign rsp_ch.total_amount   = rsp_tot_amt_ff;
   assign rsp_ch.total_interest = rsp_tot_int_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      amt_in         = amt_ff;
      int_in         = int_ff;
      qh_in          = qh_ff;
      count_in       = count_ff;
      chain_in       = chain_ff;
      last_hgt_in    = last_hgt_ff;
      last_amt_in    = last_amt_ff;
      last_int_in    = last_int_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      key_in         = key_ff;
      new_int_in     = new_int_ff;
      int_fault_in   = int_fault_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      at_amt_in      = at_amt_ff;
      at_int_in      = at_int_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_at_amt_in  = rsp_at_amt_ff;
      rsp_at_int_in  = rsp_at_int_ff;
      rsp_height_in  = rsp_height_ff;
      rsp_tot_amt_in = rsp_tot_amt_ff;
      rsp_tot_int_in = rsp_tot_int_ff;
      tbl_ctl        = '0;
      alu_op         = hirt_pkg::ALU_INTEREST;

      from_h     = (qh_ff == 32'd0) ? 32'd1 : qh_ff;
      le         = (tbl_rd.height <= key_ff);
      nlo        = le ? (mid_ff + CntW'(1)) : lo_ff;
      nhi        = le ? hi_ff : mid_ff;
      nmid       = nlo + ((nhi - nlo) >> 1);
      cnt_m1     = count_ff - CntW'(1);
      cnt_m2     = count_ff - CntW'(2);
      nlo_m1     = nlo - CntW'(1);
      push_fault = int_fault_ff || alu_fault || (chain_ff == hirt_pkg::HeightMax);
      push_adds  = (amt_ff != '0) || (int_ff != '0);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = hirt_pkg::cmd_type'(req_ch.cmd);
               amt_in   = req_ch.block_amount;
               int_in   = req_ch.block_interest;
               qh_in    = req_ch.query_height;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in  = hirt_pkg::STS_OK;
            removed_in = '0;
            at_amt_in  = '0;
            at_int_in  = '0;
            lo_in      = '0;
            hi_in      = count_ff;
            mid_in     = count_ff >> 1;
            case (cmd_ff)
               hirt_pkg::CMD_PUSH: begin
                  alu_op       = hirt_pkg::ALU_INTEREST;
                  new_int_in   = alu_sum;
                  int_fault_in = alu_fault;
                  state_in     = S_PUSH;
               end
               hirt_pkg::CMD_POP: begin
                  if (chain_ff == 32'd0) begin
                     status_in = hirt_pkg::STS_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     chain_in = chain_ff - 32'd1;
                     if ((count_ff > CntW'(1)) && (last_hgt_ff == chain_ff)) begin
                        count_in        = cnt_m1;
                        tbl_ctl.rd_en   = 1'b1;
                        tbl_ctl.rd_addr = cnt_m2[IdxW-1:0];
                        state_in        = S_LOAD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
               end
               hirt_pkg::CMD_TRUNCATE: begin
                  if (from_h > chain_ff) begin
                     state_in = S_DONE;
                  end else begin
                     removed_in      = chain_ff - from_h + 32'd1;
                     chain_in        = from_h - 32'd1;
                     key_in          = from_h - 32'd1;
                     tbl_ctl.rd_en   = 1'b1;
                     tbl_ctl.rd_addr = mid_in[IdxW-1:0];
                     state_in        = S_SEARCH;
                  end
               end
               default: begin
                  key_in          = qh_ff;
                  tbl_ctl.rd_en   = 1'b1;
                  tbl_ctl.rd_addr = mid_in[IdxW-1:0];
                  state_in        = S_SEARCH;
               end
            endcase
         end
         S_PUSH: begin
            alu_op   = hirt_pkg::ALU_AMOUNT;
            state_in = S_DONE;
            if (push_fault) begin
               status_in = hirt_pkg::STS_OVERFLOW;
            end else if (push_adds && (count_ff == CntW'(hirt_pkg::TableEntries))) begin
               status_in = hirt_pkg::STS_FULL;
            end else begin
               chain_in = chain_ff + 32'd1;
               if (push_adds) begin
                  tbl_ctl.wr_en            = 1'b1;
                  tbl_ctl.wr_addr          = count_ff[IdxW-1:0];
                  tbl_ctl.wr_data.height   = chain_ff + 32'd1;
                  tbl_ctl.wr_data.amount   = alu_sum[62:0];
                  tbl_ctl.wr_data.interest = new_int_ff;
                  count_in                 = count_ff + CntW'(1);
                  last_hgt_in              = chain_ff + 32'd1;
                  last_amt_in              = alu_sum[62:0];
                  last_int_in              = new_int_ff;
               end
            end
         end
         S_SEARCH: begin
            lo_in = nlo;
            hi_in = nhi;
            tbl_ctl.rd_en = 1'b1;
            if (nlo < nhi) begin
               mid_in          = nmid;
               tbl_ctl.rd_addr = nmid[IdxW-1:0];
            end else begin
               tbl_ctl.rd_addr = nlo_m1[IdxW-1:0];
               if (cmd_ff == hirt_pkg::CMD_TRUNCATE) begin
                  count_in = nlo;
               end
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (cmd_ff == hirt_pkg::CMD_QUERY) begin
               at_amt_in = tbl_rd.amount;
               at_int_in = tbl_rd.interest;
            end else begin
               last_hgt_in = tbl_rd.height;
               last_amt_in = tbl_rd.amount;
               last_int_in = tbl_rd.interest;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_removed_in = removed_ff;
               rsp_at_amt_in  = at_amt_ff;
               rsp_at_int_in  = at_int_ff;
               rsp_height_in  = chain_ff;
               rsp_tot_amt_in = last_amt_ff;
               rsp_tot_int_in = last_int_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= CntW'(1);
         chain_ff     <= '0;
         last_hgt_ff  <= '0;
         last_amt_ff  <= '0;
         last_int_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         chain_ff     <= chain_in;
         last_hgt_ff  <= last_hgt_in;
         last_amt_ff  <= last_amt_in;
         last_int_ff  <= last_int_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      amt_ff         <= amt_in;
      int_ff         <= int_in;
      qh_ff          <= qh_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      key_ff         <= key_in;
      new_int_ff     <= new_int_in;
      int_fault_ff   <= int_fault_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      at_amt_ff      <= at_amt_in;
      at_int_ff      <= at_int_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_at_amt_ff  <= rsp_at_amt_in;
      rsp_at_int_ff  <= rsp_at_int_in;
      rsp_height_ff  <= rsp_height_in;
      rsp_tot_amt_ff <= rsp_tot_amt_in;
      rsp_tot_int_ff <= rsp_tot_int_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CntW'(hirt_pkg::TableEntries)))
      else $error("entry count out of range");

   a_last_below_chain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (last_hgt_ff <= chain_ff))
      else $error("last entry above chain height");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> ((lo_ff < hi_ff) && (hi_ff <= count_ff)))
      else $error("search window invalid");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      tbl_ctl.wr_en |-> (tbl_ctl.wr_addr != '0))
      else $error("write to entry zero");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_DECODE))
      else $error("accepted word not decoded");
`endif

endmodule
